// ----- sv/dcfe_pkg.sv -----
package dcfe_pkg;

  localparam int unsigned StickWidth = 8;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned LimitWidth = 7;
  localparam int unsigned SumWidth   = StickWidth + 1;
  localparam int unsigned DataWidth  = 2 * ByteWidth;

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [ByteWidth-1:0]  FrameHeader = 8'hFF;
  localparam logic [ByteWidth-1:0]  WheelOffset = 8'd100;
  localparam logic [ByteWidth-1:0]  WheelMax    = 8'd200;
  localparam logic [LimitWidth-1:0] LimitMax    = 7'd100;
  localparam logic [LimitWidth-1:0] LimitReset  = 7'd60;

  // byte positions within a frame
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_LEFT   = 2'd1,
    POS_RIGHT  = 2'd2,
    POS_CHECK  = 2'd3
  } frame_pos_t;

  // one encoded frame, header implied
  typedef struct packed {
    logic [ByteWidth-1:0] left;
    logic [ByteWidth-1:0] right;
    logic [ByteWidth-1:0] check;
  } frame_t;

  // msb-first crc over one 32-bit word, low byte of the remainder
  function automatic logic [7:0] crc_low(input logic [31:0] init, input logic [31:0] word);
    logic [31:0] crc;
    crc = init ^ word;
    for (int i = 0; i < 32; i++) begin
      crc = crc[31] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
    end
    return crc[7:0];
  endfunction

  // contribution of each data bit to the check byte, worked out at elaboration
  function automatic logic [DataWidth-1:0][7:0] crc_masks();
    logic [DataWidth-1:0][7:0] m;
    for (int j = 0; j < DataWidth; j++) begin
      m[j] = crc_low(32'h0, 32'h1 << (j + 16));
    end
    return m;
  endfunction

  localparam logic [7:0] CrcBase = crc_low(CrcInit, 32'h0);
  localparam logic [DataWidth-1:0][7:0] CrcMask = crc_masks();

endpackage

// ----- sv/dcfe_if.sv -----
// joystick sample channel
interface dcfe_stick_if import dcfe_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [StickWidth-1:0] stick_x;
  logic signed [StickWidth-1:0] stick_y;
  modport source (output valid, stick_x, stick_y, input ready);
  modport sink (input valid, stick_x, stick_y, output ready);
endinterface

// frame byte channel
interface dcfe_frame_if import dcfe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] frame_byte;
  logic                 frame_last;
  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

// speed limit write channel
interface dcfe_cfg_if import dcfe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LimitWidth-1:0] speed_limit;
  modport source (output valid, speed_limit, input ready);
  modport sink (input valid, speed_limit, output ready);
endinterface

// ----- sv/drive_command_frame_encoder.sv -----
// a sample is held in the input register, then loaded into the frame register, whose
// header byte is the first byte offered on the output
// each sample becomes one frame of four bytes; the byte serialiser and any output
// stall set the sample rate
// a sample is taken while the previous frame is still being sent
// reset: synchronous, active high; empties both registers, speed limit back to 60
module drive_command_frame_encoder import dcfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  dcfe_cfg_if.sink     cfg,
  dcfe_stick_if.sink   stick,
  dcfe_frame_if.source frame
);

  logic [LimitWidth-1:0]        speed_limit;
  logic                         in_valid;
  logic signed [StickWidth-1:0] in_x;
  logic signed [StickWidth-1:0] in_y;
  frame_t                       mixed;
  logic                         item_ready;

  // configuration register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LimitReset;
    end else if (cfg.valid) begin
      speed_limit <= cfg.speed_limit;
    end
  end

  // input register
  assign stick.ready = !in_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stick.ready) begin
      in_valid <= stick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stick.valid && stick.ready) begin
      in_x <= stick.stick_x;
      in_y <= stick.stick_y;
    end
  end

  // mix, clamp and check byte
  dcfe_mix u_mix (
    .stick_x     (in_x),
    .stick_y     (in_y),
    .speed_limit (speed_limit),
    .frame       (mixed)
  );

  // frame register and byte output
  dcfe_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (mixed),
    .item_ready (item_ready),
    .frame      (frame)
  );

endmodule

// ----- sv/dcfe_mix.sv -----
module dcfe_mix import dcfe_pkg::*; (
  input  logic signed [StickWidth-1:0] stick_x,
  input  logic signed [StickWidth-1:0] stick_y,
  input  logic [LimitWidth-1:0]        speed_limit,
  output frame_t                       frame
);

  logic [LimitWidth-1:0]      lim;
  logic signed [SumWidth-1:0] lim_pos;
  logic signed [SumWidth-1:0] lim_neg;
  logic signed [SumWidth-1:0] sum_left;
  logic signed [SumWidth-1:0] sum_right;
  logic [DataWidth-1:0]       data;
  logic [ByteWidth-1:0]       check;

  // clamp a wheel value and shift it into one byte
  function automatic logic [ByteWidth-1:0] wheel_byte(
    input logic signed [SumWidth-1:0] v,
    input logic signed [SumWidth-1:0] hi,
    input logic signed [SumWidth-1:0] lo
  );
    logic signed [SumWidth-1:0] c;
    if (v > hi) begin
      c = hi;
    end else if (v < lo) begin
      c = lo;
    end else begin
      c = v;
    end
    return c[ByteWidth-1:0] + WheelOffset;
  endfunction

  // limit saturates at its ceiling
  assign lim     = (speed_limit > LimitMax) ? LimitMax : speed_limit;
  assign lim_pos = $signed({{(SumWidth-LimitWidth){1'b0}}, lim});
  assign lim_neg = -lim_pos;

  // differential mix
  assign sum_left  = SumWidth'(stick_x) + SumWidth'(stick_y);
  assign sum_right = SumWidth'(stick_y) - SumWidth'(stick_x);

  assign frame.left  = wheel_byte(sum_left, lim_pos, lim_neg);
  assign frame.right = wheel_byte(sum_right, lim_pos, lim_neg);

  // check byte as an affine map of the two wheel bytes
  assign data = {frame.left, frame.right};

  always_comb begin
    check = CrcBase;
    for (int j = 0; j < DataWidth; j++) begin
      if (data[j]) begin
        check = check ^ CrcMask[j];
      end
    end
  end

  assign frame.check = check;

endmodule

// ----- sv/dcfe_serial.sv -----
module dcfe_serial import dcfe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  frame_t item,
  output logic   item_ready,
  dcfe_frame_if.source frame
);

  logic       busy;
  frame_t     held;
  frame_pos_t pos;
  logic       last_taken;
  logic       load;

  // a new frame enters when the register is empty or its check byte leaves
  assign last_taken = busy && frame.ready && (pos == POS_CHECK);
  assign item_ready = !busy || last_taken;
  assign load       = item_valid && item_ready;

  // frame register and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_HEADER;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= POS_HEADER;
    end else if (last_taken) begin
      busy <= 1'b0;
      pos  <= POS_HEADER;
    end else if (busy && frame.ready) begin
      pos <= frame_pos_t'(pos + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

  // byte select
  always_comb begin
    unique case (pos)
      POS_HEADER: frame.frame_byte = FrameHeader;
      POS_LEFT:   frame.frame_byte = held.left;
      POS_RIGHT:  frame.frame_byte = held.right;
      POS_CHECK:  frame.frame_byte = held.check;
      default:    frame.frame_byte = FrameHeader;
    endcase
  end

  assign frame.valid      = busy;
  assign frame.frame_last = busy && (pos == POS_CHECK);

  // a frame is never replaced before its check byte has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load && busy |-> last_taken)
    else $error("frame replaced mid transmission");

  // each frame opens with the header after a load
  a_header_first: assert property (@(posedge clk) disable iff (rst)
    load |=> frame.valid && frame.frame_byte == FrameHeader && !frame.frame_last)
    else $error("frame does not start with header");

  // wheel bytes stay within the clamped range
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    busy && (pos == POS_LEFT || pos == POS_RIGHT) |-> frame.frame_byte <= WheelMax)
    else $error("wheel byte out of range");

  // position advances only on an accepted byte
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !frame.ready |=> $stable(pos) && busy)
    else $error("byte position moved while stalled");

endmodule

// ----- verif/drive_command_frame_encoder_test.sv -----
`timescale 1ns / 100ps

module drive_command_frame_encoder_test;
  import dcfe_pkg::*;

  // one frame byte still owed by the encoder
  typedef struct {
    frame_pos_t           pos;
    logic [ByteWidth-1:0] data;
    logic                 last;
  } frame_entry_t;

  // holds the speed limit copy and the frame bytes owed for accepted samples
  class wheel_frame_tracker;
    logic [LimitWidth-1:0] limit;
    frame_entry_t          owed_bytes[$];
    int unsigned           mismatches;
    int unsigned           samples_seen;
    int unsigned           bytes_checked;

    function new();
      limit         = LimitReset;
      mismatches    = 0;
      samples_seen  = 0;
      bytes_checked = 0;
    endfunction

    // one line per mismatch, quiet after the first few dozen
    task report(string what);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void set_limit(logic [LimitWidth-1:0] value);
      limit = value;
    endfunction

    // remove and return the oldest owed byte
    function frame_entry_t take_oldest();
      frame_entry_t head;
      head = owed_bytes[0];
      owed_bytes.delete(0);
      return head;
    endfunction

    // clamp a mixed wheel value and shift it into one byte
    function logic [ByteWidth-1:0] wheel_byte(int mix, int bound);
      if (mix > bound) mix = bound;
      else if (mix < -bound) mix = -bound;
      return ByteWidth'(mix + int'(WheelOffset));
    endfunction

    // low byte of the msb-first crc over left, right and two zero bytes
    function logic [ByteWidth-1:0] frame_check(logic [ByteWidth-1:0] lb,
                                               logic [ByteWidth-1:0] rb);
      logic [31:0]          rem;
      logic [ByteWidth-1:0] payload [4];
      rem     = CrcInit;
      payload = '{lb, rb, 8'h00, 8'h00};
      foreach (payload[k]) begin
        rem = rem ^ {payload[k], 24'h0};
        for (int b = 0; b < 8; b++) begin
          rem = rem[31] ? ((rem << 1) ^ CrcPoly) : (rem << 1);
        end
      end
      return rem[7:0];
    endfunction

    // accepted sample transaction: work out its four frame bytes
    function void note_sample(logic signed [StickWidth-1:0] x,
                              logic signed [StickWidth-1:0] y);
      int                   bound;
      int                   sx;
      int                   sy;
      logic [ByteWidth-1:0] lb;
      logic [ByteWidth-1:0] rb;
      bound = (limit > LimitMax) ? int'(LimitMax) : int'(limit);
      sx    = x;
      sy    = y;
      lb    = wheel_byte(sx + sy, bound);
      rb    = wheel_byte(sy - sx, bound);
      owed_bytes.push_back('{POS_HEADER, FrameHeader, 1'b0});
      owed_bytes.push_back('{POS_LEFT, lb, 1'b0});
      owed_bytes.push_back('{POS_RIGHT, rb, 1'b0});
      owed_bytes.push_back('{POS_CHECK, frame_check(lb, rb), 1'b1});
      samples_seen++;
    endfunction

    // accepted frame transaction: compare with the oldest owed byte
    task check_byte(logic [ByteWidth-1:0] data, logic last);
      frame_entry_t want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        report($sformatf("frame byte %02h (last %0b) with nothing owed", data, last));
        return;
      end
      want = take_oldest();
      if (data !== want.data)
        report($sformatf("%s byte %02h, expected %02h", want.pos.name(), data, want.data));
      if (last !== want.last)
        report($sformatf("%s last flag %0b, expected %0b", want.pos.name(), last,
                         want.last));
    endtask

    task flush_leftovers();
      frame_entry_t want;
      while (owed_bytes.size() != 0) begin
        want = take_oldest();
        report($sformatf("%s byte %02h never arrived", want.pos.name(), want.data));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  wheel_frame_tracker tracker = new();

  logic        calm = 1'b0;
  int          hold_len = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned limit_writes = 0;

  dcfe_cfg_if   cfg_ch ();
  dcfe_stick_if stick_ch ();
  dcfe_frame_if frame_ch ();

  drive_command_frame_encoder DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .stick (stick_ch),
    .frame (frame_ch)
  );

  always #5 clk = ~clk;

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // transaction monitor on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.set_limit(cfg_ch.speed_limit);
        limit_writes++;
      end
      if (stick_ch.valid && stick_ch.ready)
        tracker.note_sample(stick_ch.stick_x, stick_ch.stick_y);
      else if (stick_ch.valid)
        input_stall_cycles++;
      if (frame_ch.valid && frame_ch.ready)
        tracker.check_byte(frame_ch.frame_byte, frame_ch.frame_last);
    end
  end

  // frame receiver: random stalls, plus a long hold-off counted here
  initial begin : receiver
    int stall;
    stall = 0;
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        frame_ch.ready = 1'b0;
        hold_len--;
      end else if (stall > 0) begin
        frame_ch.ready = 1'b0;
        stall--;
      end else begin
        frame_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // offer one sample, wait for its transaction, then maybe idle
  task automatic send_sample(logic signed [StickWidth-1:0] x,
                             logic signed [StickWidth-1:0] y);
    int gap;
    @(negedge clk);
    stick_ch.valid   = 1'b1;
    stick_ch.stick_x = x;
    stick_ch.stick_y = y;
    @(posedge clk);
    while (!stick_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      stick_ch.valid   = 1'b0;
      stick_ch.stick_x = StickWidth'($urandom);
      stick_ch.stick_y = StickWidth'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // half full range, half close to the clamp bounds
  task automatic send_random();
    logic signed [StickWidth-1:0] x;
    logic signed [StickWidth-1:0] y;
    if ($urandom_range(0, 1)) begin
      x = StickWidth'($urandom);
      y = StickWidth'($urandom);
    end else begin
      x = StickWidth'(int'($urandom_range(0, 120)) - 60);
      y = StickWidth'(int'($urandom_range(0, 120)) - 60);
    end
    send_sample(x, y);
  endtask

  // stop offering and let every owed byte come out
  task automatic drain();
    @(negedge clk);
    stick_ch.valid = 1'b0;
    while (tracker.owed_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [LimitWidth-1:0] value);
    drain();
    @(negedge clk);
    cfg_ch.valid       = 1'b1;
    cfg_ch.speed_limit = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin : stimulus
    logic signed [StickWidth-1:0] corner_x [12];
    logic signed [StickWidth-1:0] corner_y [12];
    logic [LimitWidth-1:0]        phase_limit;
    corner_x = '{-128, 127, -128, 127, 0, 30, 30, -30, -31, 0, 1, -1};
    corner_y = '{-128, 127, 127, -128, 0, 30, 31, -30, -30, -128, 1, -1};
    stick_ch.valid     = 1'b0;
    stick_ch.stick_x   = '0;
    stick_ch.stick_y   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.speed_limit = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // field extremes and clamp edges at the reset limit
    foreach (corner_x[i]) send_sample(corner_x[i], corner_y[i]);

    // limit of zero: both wheels stop
    write_limit(7'd0);
    send_sample(127, 127);
    send_sample(-128, 5);

    // limit above range acts as the maximum
    write_limit(7'd127);
    send_sample(127, 127);
    send_sample(-128, -128);
    send_sample(-128, 127);

    // exactly at the maximum
    write_limit(LimitMax);
    send_sample(50, 50);
    send_sample(-51, -50);

    // random phases, each with its own limit
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: phase_limit = 7'd1;
        1: phase_limit = 7'd101;
        2: phase_limit = 7'd99;
        default: phase_limit = LimitWidth'($urandom_range(0, 127));
      endcase
      write_limit(phase_limit);
      calm = (p == 4) || ($urandom_range(0, 3) == 0);
      // long receiver hold-off while samples keep coming
      if (p == 4) begin
        @(posedge clk);
        hold_len = 300;
      end
      repeat (42) send_random();
      calm = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    tracker.flush_leftovers();
    $display("%0d joystick samples encoded under %0d speed limit settings, %0d frame bytes checked",
             tracker.samples_seen, limit_writes + 1, tracker.bytes_checked);
    $display("encoder back-pressured the sample input for %0d cycles", input_stall_cycles);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
